// ===== src/tmps_pkg.sv =====
// Shared types and constants for the triangle maximum path sum block.
package tmps_pkg;

  localparam int CNT_W = 10;
  localparam int VAL_W = 15;
  localparam int SUM_W = 24;
  localparam int WIDE_W = SUM_W + 1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // how the new sum is formed from its parents
  typedef enum logic [1:0] {
    OP_FIRST = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_MID   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             last_row;
    logic             emit;
    logic [CNT_W-1:0] col_m1;
  } step_t;

endpackage

// ===== src/tmps_ctrl.sv =====
// Row and column sequencing, row count register and per-beat step decode.
module tmps_ctrl
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_row_count,
  input  logic             in_fire,
  output step_t            step
);

  localparam logic [CNT_W-1:0] MaxRowsC = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] OneC     = CNT_W'(1);

  logic [CNT_W-1:0] rows_cfg_r;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] rows_eff;
  logic             row_end;

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = OneC;
    end else if (rows_cfg_r > MaxRowsC) begin
      rows_eff = MaxRowsC;
    end else begin
      rows_eff = rows_cfg_r;
    end
  end

  assign row_end = (col_r >= row_r);

  always_comb begin
    step.last_row = (row_r >= rows_eff);
    step.emit     = row_end && step.last_row;
    step.col_m1   = col_r - OneC;
    if (row_r == OneC) begin
      step.op = OP_FIRST;
    end else if (col_r == OneC) begin
      step.op = OP_LEFT;
    end else if (col_r == row_r) begin
      step.op = OP_RIGHT;
    end else begin
      step.op = OP_MID;
    end
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_fire) begin
      if (row_end) begin
        col_nxt = OneC;
        row_nxt = step.last_row ? OneC : row_r + OneC;
      end else begin
        col_nxt = col_r + OneC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= OneC;
      row_r      <= OneC;
      col_r      <= OneC;
    end else begin
      if (cfg_wr_en) begin
        rows_cfg_r <= cfg_row_count;
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r >= OneC && row_r <= MaxRowsC)
    else $error("row index out of range");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r >= OneC && col_r <= row_r)
    else $error("column beyond current row");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && step.emit |=> row_r == OneC && col_r == OneC)
    else $error("counters not restarted after final beat");

endmodule

// ===== src/triangle_max_path_sum_core.sv =====
// Top level of the triangle maximum path sum block: row store, update stage, result register.
//
// Triangle entries arrive on the in_ channel (in_valid/in_ready/in_value), one
// beat per entry, row by row and left to right. cfg_wr_en with cfg_row_count
// sets the number of rows (zero counts as one, values above MAX_ROWS saturate);
// write it only while the block is idle.
// After the final entry of the last row one beat leaves on the out_ channel
// (out_valid/out_ready/out_best_sum) carrying the maximum path sum; no other
// entry produces a result.
// Throughput: one entry per cycle while no result waits on out_ready. Each beat issues
// one row-store read on acceptance and one write when it leaves the update stage; a
// write-forwarding register covers a read of an entry issued as that entry is written.
// Result: out_valid is registered and rises once the final entry's beat leaves the update stage.
// Reset: the row count returns to one and the next entry starts a new
// triangle. The row store is not cleared; only entries of the previous row
// are read.
// Stall: a waiting result holds the update stage only when the next result is
// due, so in_ready drops for at most the final entry of a triangle.
module triangle_max_path_sum_core
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = 512
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CNT_W-1:0]        cfg_row_count,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] out_best_sum
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [SUM_W-1:0] row_mem [MAX_ROWS];

  step_t                    step;
  logic                     in_fire;
  logic                     s1_fire;
  logic                     s1_valid_r;
  step_t                    s1_step_r;
  logic signed [VAL_W-1:0]  s1_value_r;
  logic [SUM_W-1:0]         rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            s1_addr;

  logic                     fwd_valid_r;
  logic [AW-1:0]            fwd_addr_r;
  logic [SUM_W-1:0]         fwd_data_r;

  logic signed [SUM_W-1:0]  held_r;
  logic signed [SUM_W-1:0]  best_r;
  logic signed [SUM_W-1:0]  above;
  logic signed [SUM_W-1:0]  base;
  logic signed [WIDE_W-1:0] sum_wide;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  best_nxt;

  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  out_best_sum_r;

  tmps_ctrl #(
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_row_count(cfg_row_count),
    .in_fire      (in_fire),
    .step         (step)
  );

  assign s1_fire  = s1_valid_r && !(s1_step_r.emit && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign rd_addr  = step.col_m1[AW-1:0];
  assign s1_addr  = s1_step_r.col_m1[AW-1:0];

  // row store: read on acceptance, write back from the update stage
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      row_mem[s1_addr] <= sum;
    end
    if (in_fire) begin
      rd_data_r <= row_mem[rd_addr];
    end
  end

  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s1_addr) begin
      above = fwd_data_r;
    end else begin
      above = rd_data_r;
    end
    case (s1_step_r.op)
      OP_FIRST: base = '0;
      OP_LEFT:  base = above;
      OP_RIGHT: base = held_r;
      OP_MID:   base = (above > held_r) ? above : held_r;
      default:  base = '0;
    endcase
    sum_wide = WIDE_W'(base) + WIDE_W'(s1_value_r);
    if (sum_wide > WIDE_W'(SUM_MAX)) begin
      sum = SUM_MAX;
    end else if (sum_wide < WIDE_W'(SUM_MIN)) begin
      sum = SUM_MIN;
    end else begin
      sum = sum_wide[SUM_W-1:0];
    end
    best_nxt = (s1_step_r.last_row && sum > best_r) ? sum : best_r;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_step_r  <= step;
      s1_value_r <= in_value;
    end
    if (s1_fire) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= sum;
    end
    if (s1_fire && s1_step_r.emit) begin
      out_best_sum_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      held_r      <= '0;
      best_r      <= SUM_MIN;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        fwd_valid_r <= 1'b1;
        if (s1_step_r.emit) begin
          held_r <= '0;
          best_r <= SUM_MIN;
        end else begin
          best_r <= best_nxt;
          if (s1_step_r.op == OP_LEFT || s1_step_r.op == OP_MID) begin
            held_r <= above;
          end
        end
      end
      if (s1_fire && s1_step_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_best_sum = out_best_sum_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |-> !in_fire)
    else $error("beat accepted while update stage stalled");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_step_r.emit |-> !out_valid_r || out_ready)
    else $error("result would overwrite a waiting beat");

  a_best_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_step_r.emit |=> best_r == SUM_MIN && out_valid_r)
    else $error("running best not restarted after result");

endmodule

// ===== verif/tb_triangle_max_path_sum_core.sv =====
// Self-checking testbench for triangle_max_path_sum_core: streamed triangles with a predictor.
module tb_triangle_max_path_sum_core;
  import tmps_pkg::*;

  localparam int MAX_ROWS = 512;
  localparam int SUM_HI = int'(SUM_MAX);
  localparam int SUM_LO = int'(SUM_MIN);
  localparam int IDLE_WAIT = 4;
  localparam int TIMEOUT_CYCLES = 4000000;
  localparam int RANDOM_ENTRIES = 900;

  typedef struct {
    bit                      is_cfg;
    logic [CNT_W-1:0]        rows;
    logic signed [VAL_W-1:0] value;
  } beat_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]        cfg_row_count = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_best_sum;

  beat_t                   pending_beats[$];
  logic signed [SUM_W-1:0] due_best_sums[$];
  logic                    in_took = 1'b0;
  int                      quiet_cycles = 0;
  int                      burst_left = 8;
  int                      gap_left = 0;
  logic [15:0]             ready_bits = 16'hffff;
  int                      ready_pos = 0;
  int                      mismatches = 0;
  int                      cycles = 0;

  // predictor state
  int unsigned rows_reg;
  int          sums_row[MAX_ROWS];
  int unsigned row_at;
  int unsigned col_at;
  int          held_parent;
  int          best_last;

  triangle_max_path_sum_core #(.MAX_ROWS(MAX_ROWS)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_row_count (cfg_row_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_best_sum  (out_best_sum)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void restart_triangle();
    row_at = 1;
    col_at = 1;
    held_parent = 0;
    best_last = SUM_LO;
  endfunction

  // one entry through the in-place row update; returns 1 when the triangle completes
  function automatic bit fold_entry(input int v, output int best);
    int unsigned rows;
    int unsigned col;
    int unsigned slot;
    int          total;
    int          above;
    bit          last;
    rows = (rows_reg < 1) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    if (row_at < 1) row_at = 1;
    if (row_at > MAX_ROWS) row_at = MAX_ROWS;
    col = col_at;
    if (col < 1) col = 1;
    if (col > row_at) col = row_at;
    slot = (col - 1) % MAX_ROWS;
    if (row_at == 1) begin
      total = v;
    end else if (col == 1) begin
      above = sums_row[slot];
      total = above + v;
      held_parent = above;
    end else if (col == row_at) begin
      total = held_parent + v;
    end else begin
      above = sums_row[slot];
      total = ((above > held_parent) ? above : held_parent) + v;
      held_parent = above;
    end
    if (total > SUM_HI) total = SUM_HI;
    if (total < SUM_LO) total = SUM_LO;
    sums_row[slot] = total;
    last = (row_at >= rows);
    if (last && total > best_last) best_last = total;
    best = best_last;
    if (col >= row_at) begin
      if (last) begin
        restart_triangle();
        return 1'b1;
      end
      row_at++;
      col_at = 1;
    end else begin
      col_at = col + 1;
    end
    return 1'b0;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_W'($urandom);
      1:       return ($urandom_range(0, 1) == 1) ? 15'sh3fff : 15'sh4000;
      2:       return VAL_W'(int'($urandom_range(0, 200)) - 100);
      default: return VAL_W'(int'($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  task automatic push_rows(input int n);
    beat_t b;
    b.is_cfg = 1'b1;
    b.rows = CNT_W'(n);
    b.value = '0;
    pending_beats.push_back(b);
  endtask

  task automatic push_value(input logic signed [VAL_W-1:0] v);
    beat_t b;
    b.is_cfg = 1'b0;
    b.rows = '0;
    b.value = v;
    pending_beats.push_back(b);
  endtask

  task automatic push_triangle(input int n, output int cnt);
    int eff;
    eff = (n < 1) ? 1 : ((n > MAX_ROWS) ? MAX_ROWS : n);
    cnt = eff * (eff + 1) / 2;
    for (int i = 0; i < cnt; i++) push_value(pick_value());
  endtask

  // driver: beats change on the falling edge
  always @(negedge clk) begin : drive
    logic                    nv;
    logic                    nw;
    logic signed [VAL_W-1:0] nd;
    logic [CNT_W-1:0]        nc;
    nv = in_valid;
    nd = in_value;
    nw = 1'b0;
    nc = cfg_row_count;
    if (rst_n) begin
      if (in_valid && in_took) nv = 1'b0;
      if (!nv && pending_beats.size() > 0) begin
        if (pending_beats[0].is_cfg) begin
          if (quiet_cycles >= IDLE_WAIT) begin
            nw = 1'b1;
            nc = pending_beats[0].rows;
            void'(pending_beats.pop_front());
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          nv = 1'b1;
          nd = pending_beats[0].value;
          void'(pending_beats.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(4, 32);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    in_valid <= nv;
    in_value <= nd;
    cfg_wr_en <= nw;
    cfg_row_count <= nc;
  end

  // receiver stall pattern, reloaded after all 16 of its bits are used
  always @(negedge clk) begin
    if (ready_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_bits = 16'hffff;
        1:       ready_bits = 16'h00ff;
        default: ready_bits = 16'($urandom) | 16'h0001;
      endcase
    end
    out_ready <= ready_bits[ready_pos];
    ready_pos = (ready_pos + 1) % 16;
  end

  // monitor and scoreboard
  always @(posedge clk) begin : check
    int                      best;
    logic signed [SUM_W-1:0] want;
    if (!rst_n) begin
      rows_reg = 1;
      foreach (sums_row[i]) sums_row[i] = 0;
      restart_triangle();
      in_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_wr_en) rows_reg = cfg_row_count;
      if (in_valid && in_ready) begin
        if (fold_entry(int'(in_value), best)) due_best_sums.push_back(SUM_W'(best));
      end
      if (out_valid && out_ready) begin
        if (due_best_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected best_sum beat: %0d", out_best_sum);
        end else begin
          want = due_best_sums.pop_front();
          if (out_best_sum !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("best_sum mismatch: expected %0d, got %0d", want, out_best_sum);
          end
        end
      end
      in_took <= in_valid && in_ready;
      quiet_cycles <= (in_valid || due_best_sums.size() > 0) ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int cnt;
    int random_entries;
    random_entries = 0;

    // single-row triangles at the reset row count, then row count zero
    push_value(15'sh3fff);
    push_value(15'sh4000);
    push_rows(0);
    push_value(15'sh0000);
    // three rows: left edge, middle and right edge updates
    push_rows(3);
    push_value(15'sd5);
    push_value(15'sh4000);
    push_value(15'sh3fff);
    push_value(15'sd7);
    push_value(-15'sd1);
    push_value(15'sd100);
    push_rows(2);
    push_value(15'sh4000);
    push_value(15'sh4000);
    push_value(15'sh4000);
    push_rows(1);
    push_value(-15'sd10000);

    // row count above the store depth saturates; a lower count mid-triangle
    // makes the fifth row the last one
    push_rows(1023);
    for (int i = 0; i < 10; i++) push_value(pick_value());
    push_rows(2);
    for (int i = 0; i < 5; i++) push_value(pick_value());

    while (random_entries < RANDOM_ENTRIES) begin
      case ($urandom_range(0, 15))
        0:       n = 0;
        1:       n = $urandom_range(12, 20);
        default: n = $urandom_range(1, 9);
      endcase
      push_rows(n);
      push_triangle(n, cnt);
      random_entries += cnt;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() > 0 || in_valid || due_best_sums.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_best_sums.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
